// File: hdl/hsc_pkg.sv
// Shared constants and types for the heap sorter with swap counting.
package hsc_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int CHILD_W      = ADDR_W + 2;
  localparam int VALUE_W      = 32;
  localparam int SWAP_W       = 16;
  localparam int OUT_W        = VALUE_W + SWAP_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // Classified input word handed from front to back.
  typedef struct packed {
    logic                      last;
    logic                      store;
    logic signed [VALUE_W-1:0] value;
  } hsc_word_t;

endpackage

// File: hdl/heap_sorter_swap_count_unit.sv
// Heap sorter top level: front, word queue and sort engine.
// Words load one per cycle into a 64-entry store while the engine is loading;
// the word with tlast closes the set (words past 64 are dropped, their tlast
// still counts). The engine then builds a max-heap and heap-sorts in place
// on the two-read-port element memory: each sift-down level reads both
// children and then compares and writes, each build node first reads the node,
// each sort step first swaps the root with the last element, and each result
// is read and then held on the output until taken. Results come out in
// ascending order, each with the saturating swap count of its set. A four-word
// queue keeps taking input words while a set is being sorted or drained.
module heap_sorter_swap_count_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // [31:0] value
  input  logic                       s_tlast,   // last_item
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [47:0]                m_tdata,   // [31:0] sorted_value, [47:32] swap_count
  output logic                       m_tlast    // last_result
);
  import hsc_pkg::*;

  hsc_word_t push_word;
  hsc_word_t pop_word;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_avail;

  hsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (push_word)
  );

  hsc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_word  (pop_word)
  );

  hsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_word   (pop_word),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: hdl/hsc_front.sv
// Input side: accepts words and marks whether each one fits in the store.
module hsc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic signed [hsc_pkg::VALUE_W-1:0] s_tdata,  // value
  input  logic                            s_tlast,  // last_item
  input  logic                            q_full,
  output logic                            q_push,
  output hsc_pkg::hsc_word_t              q_word
);
  import hsc_pkg::*;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic             room;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign room     = fill < CNT_W'(MAX_ELEMENTS);

  assign q_word.last  = s_tlast;
  assign q_word.store = room;
  assign q_word.value = s_tdata;

  always_comb begin
    fill_next = fill;
    if (q_push) begin
      if (s_tlast) begin
        fill_next = '0;
      end else if (room) begin
        fill_next = fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

// File: hdl/hsc_fifo.sv
// Short queue of classified words between front and back.
module hsc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hsc_pkg::hsc_word_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               avail,
  output hsc_pkg::hsc_word_t pop_word
);
  import hsc_pkg::*;

  hsc_word_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   level;

  assign full     = level == (QPTR_W+1)'(QUEUE_DEPTH);
  assign avail    = level != '0;
  assign pop_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        level <= level - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: hdl/hsc_back.sv
// Sort engine: element memory, heap build, heap sort and result output.
module hsc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_avail,
  input  hsc_pkg::hsc_word_t             q_word,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hsc_pkg::OUT_W-1:0]      m_tdata,
  output logic                           m_tlast
);
  import hsc_pkg::*;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_BNEXT = 4'd1;
  localparam logic [3:0] ST_SV    = 4'd2;
  localparam logic [3:0] ST_RDC   = 4'd3;
  localparam logic [3:0] ST_CMP   = 4'd4;
  localparam logic [3:0] ST_TNEXT = 4'd5;
  localparam logic [3:0] ST_TSWP  = 4'd6;
  localparam logic [3:0] ST_ORD   = 4'd7;
  localparam logic [3:0] ST_OHOLD = 4'd8;

  logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] rd0;
  logic signed [VALUE_W-1:0] rd1;
  logic [ADDR_W-1:0]         ra0;
  logic [ADDR_W-1:0]         ra1;
  logic                      we;
  logic [ADDR_W-1:0]         wa;
  logic signed [VALUE_W-1:0] wd;

  logic [3:0]                state, state_next;
  logic [CNT_W-1:0]          loaded, loaded_next;
  logic [CNT_W-1:0]          limit, limit_next;
  logic [CNT_W-1:0]          bk, bk_next;
  logic [CNT_W-1:0]          sk, sk_next;
  logic [ADDR_W-1:0]         node, node_next;
  logic [ADDR_W-1:0]         ok, ok_next;
  logic signed [VALUE_W-1:0] v, v_next;
  logic [SWAP_W-1:0]         swaps, swaps_next;
  logic                      sorting, sorting_next;

  logic [CHILD_W-1:0]        lidx;
  logic [CHILD_W-1:0]        ridx;
  logic                      lok;
  logic                      rok;
  logic [1:0]                pick;
  logic signed [VALUE_W-1:0] bigv;
  logic [CNT_W-1:0]          nload;
  logic                      out_last;

  assign lidx = CHILD_W'({node, 1'b1});
  assign ridx = lidx + CHILD_W'(1);
  assign lok  = lidx < CHILD_W'(limit);
  assign rok  = ridx < CHILD_W'(limit);
  assign nload = loaded + CNT_W'(q_word.store);
  assign out_last = (CNT_W'(ok) + CNT_W'(1)) == loaded;

  // largest of node, left, right; strict compares keep ties in place
  always_comb begin
    bigv = v;
    pick = 2'd0;
    if (lok && (rd0 > v)) begin
      bigv = rd0;
      pick = 2'd1;
    end
    if (rok && (rd1 > bigv)) begin
      bigv = rd1;
      pick = 2'd2;
    end
  end

  assign q_pop    = (state == ST_LOAD) && q_avail;
  assign m_tvalid = state == ST_OHOLD;
  assign m_tdata  = {swaps, rd0};
  assign m_tlast  = out_last;

  always_comb begin
    state_next   = state;
    loaded_next  = loaded;
    limit_next   = limit;
    bk_next      = bk;
    sk_next      = sk;
    node_next    = node;
    ok_next      = ok;
    v_next       = v;
    swaps_next   = swaps;
    sorting_next = sorting;
    ra0 = ok;
    ra1 = '0;
    we  = 1'b0;
    wa  = node;
    wd  = v;
    unique case (state)
      ST_LOAD: begin
        if (q_avail) begin
          if (q_word.store) begin
            we = 1'b1;
            wa = loaded[ADDR_W-1:0];
            wd = q_word.value;
          end
          loaded_next = nload;
          if (q_word.last) begin
            limit_next   = nload;
            bk_next      = nload >> 1;
            sk_next      = nload;
            swaps_next   = '0;
            sorting_next = 1'b0;
            state_next   = ST_BNEXT;
          end
        end
      end
      ST_BNEXT: begin
        if (bk == '0) begin
          sorting_next = 1'b1;
          state_next   = ST_TNEXT;
        end else begin
          ra0        = ADDR_W'(bk - CNT_W'(1));
          node_next  = ADDR_W'(bk - CNT_W'(1));
          bk_next    = bk - CNT_W'(1);
          state_next = ST_SV;
        end
      end
      ST_SV: begin
        v_next     = rd0;
        ra0        = lidx[ADDR_W-1:0];
        ra1        = ridx[ADDR_W-1:0];
        state_next = ST_CMP;
      end
      ST_RDC: begin
        ra0        = lidx[ADDR_W-1:0];
        ra1        = ridx[ADDR_W-1:0];
        state_next = ST_CMP;
      end
      ST_CMP: begin
        we = 1'b1;
        wa = node;
        if (pick != 2'd0) begin
          wd = bigv;
          node_next = (pick == 2'd1) ? lidx[ADDR_W-1:0] : ridx[ADDR_W-1:0];
          if (swaps != '1) begin
            swaps_next = swaps + SWAP_W'(1);
          end
          state_next = ST_RDC;
        end else begin
          wd = v;
          state_next = sorting ? ST_TNEXT : ST_BNEXT;
        end
      end
      ST_TNEXT: begin
        if (sk == '0) begin
          ok_next    = '0;
          state_next = ST_ORD;
        end else begin
          ra0        = '0;
          ra1        = ADDR_W'(sk - CNT_W'(1));
          state_next = ST_TSWP;
        end
      end
      ST_TSWP: begin
        we         = 1'b1;
        wa         = ADDR_W'(sk - CNT_W'(1));
        wd         = rd0;
        v_next     = rd1;
        limit_next = sk - CNT_W'(1);
        sk_next    = sk - CNT_W'(1);
        node_next  = '0;
        state_next = ST_RDC;
      end
      ST_ORD: begin
        state_next = ST_OHOLD;
      end
      ST_OHOLD: begin
        if (m_tready) begin
          if (out_last) begin
            loaded_next = '0;
            limit_next  = '0;
            swaps_next  = '0;
            state_next  = ST_LOAD;
          end else begin
            ok_next    = ok + ADDR_W'(1);
            state_next = ST_ORD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    v    <= v_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      loaded  <= '0;
      limit   <= '0;
      bk      <= '0;
      sk      <= '0;
      ok      <= '0;
      swaps   <= '0;
      sorting <= 1'b0;
    end else begin
      state   <= state_next;
      loaded  <= loaded_next;
      limit   <= limit_next;
      bk      <= bk_next;
      sk      <= sk_next;
      ok      <= ok_next;
      swaps   <= swaps_next;
      sorting <= sorting_next;
    end
  end

endmodule

// File: hdl/hsc_checker.sv
// Port-level checks for the heap sorter, bound to the top level.
module hsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);
  import hsc_pkg::*;

  logic                   in_frame;
  logic [VALUE_W-1:0]     prev_val;
  logic [SWAP_W-1:0]      prev_swaps;
  logic [CNT_W-1:0]       seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      seen     <= '0;
    end else if (m_tvalid && m_tready) begin
      in_frame <= !m_tlast;
      seen     <= m_tlast ? '0 : seen + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      prev_val   <= m_tdata[VALUE_W-1:0];
      prev_swaps <= m_tdata[OUT_W-1:VALUE_W];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && in_frame |-> $signed(m_tdata[VALUE_W-1:0]) >= $signed(prev_val))
    else $error("results not ascending");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && in_frame |-> m_tdata[OUT_W-1:VALUE_W] == prev_swaps)
    else $error("swap count differs within a set");

  a_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen == CNT_W'(MAX_ELEMENTS - 1) |-> m_tlast)
    else $error("set longer than the store");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind heap_sorter_swap_count_unit hsc_checker u_hsc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
